/* rtl/mieu_pkg.sv */
// ----------------------------------------------------------------------------
// MIPS integer execute unit package
// Operation codes, widths and the classification record shared by the units.
// ----------------------------------------------------------------------------
package mieu_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned OpWidth    = 6;
  localparam int unsigned ShWidth    = 5;
  localparam int unsigned ImmWidth   = 26;
  localparam int unsigned QueueDepth = 2;

  localparam logic [OpWidth-1:0] OP_SLL   = 6'd0;
  localparam logic [OpWidth-1:0] OP_SRL   = 6'd1;
  localparam logic [OpWidth-1:0] OP_SRA   = 6'd2;
  localparam logic [OpWidth-1:0] OP_SLLV  = 6'd3;
  localparam logic [OpWidth-1:0] OP_SRLV  = 6'd4;
  localparam logic [OpWidth-1:0] OP_SRAV  = 6'd5;
  localparam logic [OpWidth-1:0] OP_JR    = 6'd6;
  localparam logic [OpWidth-1:0] OP_JALR  = 6'd7;
  localparam logic [OpWidth-1:0] OP_MOVZ  = 6'd8;
  localparam logic [OpWidth-1:0] OP_MOVN  = 6'd9;
  localparam logic [OpWidth-1:0] OP_MFHI  = 6'd10;
  localparam logic [OpWidth-1:0] OP_MTHI  = 6'd11;
  localparam logic [OpWidth-1:0] OP_MFLO  = 6'd12;
  localparam logic [OpWidth-1:0] OP_MTLO  = 6'd13;
  localparam logic [OpWidth-1:0] OP_MULT  = 6'd14;
  localparam logic [OpWidth-1:0] OP_MULTU = 6'd15;
  localparam logic [OpWidth-1:0] OP_DIV   = 6'd16;
  localparam logic [OpWidth-1:0] OP_DIVU  = 6'd17;
  localparam logic [OpWidth-1:0] OP_ADD   = 6'd18;
  localparam logic [OpWidth-1:0] OP_ADDU  = 6'd19;
  localparam logic [OpWidth-1:0] OP_SUB   = 6'd20;
  localparam logic [OpWidth-1:0] OP_SUBU  = 6'd21;
  localparam logic [OpWidth-1:0] OP_AND   = 6'd22;
  localparam logic [OpWidth-1:0] OP_OR    = 6'd23;
  localparam logic [OpWidth-1:0] OP_XOR   = 6'd24;
  localparam logic [OpWidth-1:0] OP_NOR   = 6'd25;
  localparam logic [OpWidth-1:0] OP_SLT   = 6'd26;
  localparam logic [OpWidth-1:0] OP_SLTU  = 6'd27;
  localparam logic [OpWidth-1:0] OP_J     = 6'd28;
  localparam logic [OpWidth-1:0] OP_JAL   = 6'd29;
  localparam logic [OpWidth-1:0] OP_BEQ   = 6'd30;
  localparam logic [OpWidth-1:0] OP_BNE   = 6'd31;
  localparam logic [OpWidth-1:0] OP_BLEZ  = 6'd32;
  localparam logic [OpWidth-1:0] OP_BGTZ  = 6'd33;
  localparam logic [OpWidth-1:0] OP_ADDI  = 6'd34;
  localparam logic [OpWidth-1:0] OP_ADDIU = 6'd35;
  localparam logic [OpWidth-1:0] OP_SLTI  = 6'd36;
  localparam logic [OpWidth-1:0] OP_SLTIU = 6'd37;
  localparam logic [OpWidth-1:0] OP_ANDI  = 6'd38;
  localparam logic [OpWidth-1:0] OP_ORI   = 6'd39;
  localparam logic [OpWidth-1:0] OP_XORI  = 6'd40;
  localparam logic [OpWidth-1:0] OP_LUI   = 6'd41;

  localparam logic [WordWidth-1:0] PcStep      = 32'h4;
  localparam logic [WordWidth-1:0] SextMask    = 32'hFFFF0000;
  localparam logic [WordWidth-1:0] RegionMask  = 32'hF0000000;

  // Item class chosen by the front end.
  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2
  } item_class_t;

  // One classified item as held in the queue.
  typedef struct packed {
    logic [OpWidth-1:0]   op;
    item_class_t          cls;
    logic                 is_signed;
    logic [WordWidth-1:0] rs_value;
    logic [WordWidth-1:0] rt_value;
    logic [ShWidth-1:0]   shift_amount;
    logic [ImmWidth-1:0]  immediate_field;
    logic [WordWidth-1:0] pc_value;
  } queue_item_t;

endpackage

/* rtl/mieu_front.sv */
// ----------------------------------------------------------------------------
// MIPS integer execute unit front end
// Accepts input beats, classifies them and keeps a short queue for the back end.
// ----------------------------------------------------------------------------
module mieu_front
  import mieu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  output logic                 stall,
  input  logic [OpWidth-1:0]   op,
  input  logic [WordWidth-1:0] rs_value,
  input  logic [WordWidth-1:0] rt_value,
  input  logic [ShWidth-1:0]   shift_amount,
  input  logic [ImmWidth-1:0]  immediate_field,
  input  logic [WordWidth-1:0] pc_value,
  output logic                 q_valid,
  input  logic                 q_take,
  output queue_item_t          q_item
);

  localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  queue_item_t          slots [QueueDepth];
  logic [PtrWidth-1:0]  wr_ptr;
  logic [PtrWidth-1:0]  rd_ptr;
  logic [PtrWidth:0]    count;
  queue_item_t          incoming;
  logic                 push;
  logic                 pop;

  // Classify the beat.
  always_comb begin
    incoming.op              = op;
    incoming.rs_value        = rs_value;
    incoming.rt_value        = rt_value;
    incoming.shift_amount    = shift_amount;
    incoming.immediate_field = immediate_field;
    incoming.pc_value        = pc_value;
    incoming.is_signed       = (op == OP_MULT) || (op == OP_DIV);
    case (op)
      OP_MULT, OP_MULTU: incoming.cls = CLS_MUL;
      OP_DIV, OP_DIVU:   incoming.cls = CLS_DIV;
      default:           incoming.cls = CLS_SIMPLE;
    endcase
  end

  assign stall   = (count == (PtrWidth+1)'(QueueDepth));
  assign push    = valid && !stall;
  assign q_valid = (count != '0);
  assign pop     = q_valid && q_take;
  assign q_item  = slots[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(QueueDepth-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(QueueDepth-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PtrWidth+1)'(push) - (PtrWidth+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= (PtrWidth+1)'(QueueDepth))
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("push lost");

endmodule

/* rtl/mieu_muldiv.sv */
// ----------------------------------------------------------------------------
// MIPS integer execute unit multiply and divide
// Multiplies as four 16x16 partial products and divides one bit a cycle.
// ----------------------------------------------------------------------------
module mieu_muldiv
  import mieu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 is_div,
  input  logic                 is_signed,
  input  logic [WordWidth-1:0] a,
  input  logic [WordWidth-1:0] b,
  output logic                 done,
  output logic [WordWidth-1:0] hi_out,
  output logic [WordWidth-1:0] lo_out
);

  localparam int unsigned CntWidth = $clog2(WordWidth) + 1;
  localparam int unsigned Half     = WordWidth / 2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_FIX  = 2'd3
  } state_t;

  state_t                 state;
  logic [CntWidth-1:0]    cnt;
  logic [WordWidth-1:0]   ma;
  logic [WordWidth-1:0]   mb;
  logic                   neg_q;
  logic                   neg_r;
  logic [2*WordWidth-1:0] acc;
  logic [WordWidth-1:0]   quot;
  logic [WordWidth:0]     rem;
  logic [WordWidth-1:0]   abs_a;
  logic [WordWidth-1:0]   abs_b;
  logic [WordWidth:0]     rem_shift;
  logic [WordWidth:0]     rem_diff;
  logic [Half-1:0]        pa;
  logic [Half-1:0]        pb;
  logic [WordWidth-1:0]   pprod;
  logic [2*WordWidth-1:0] pprod_shift;
  logic [2*WordWidth-1:0] acc_neg;

  assign abs_a = (is_signed && a[WordWidth-1]) ? -a : a;
  assign abs_b = (is_signed && b[WordWidth-1]) ? -b : b;

  // Partial product selected by the step counter.
  assign pa          = cnt[0] ? ma[WordWidth-1:Half] : ma[Half-1:0];
  assign pb          = cnt[1] ? mb[WordWidth-1:Half] : mb[Half-1:0];
  assign pprod       = pa * pb;
  assign pprod_shift = {{WordWidth{1'b0}}, pprod}
                       << ((cnt[0] ? Half : 0) + (cnt[1] ? Half : 0));

  // Restoring division step.
  assign rem_shift = {rem[WordWidth-1:0], quot[WordWidth-1]};
  assign rem_diff  = rem_shift - {1'b0, mb};
  assign acc_neg   = -acc;

  assign done = (state == ST_FIX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            ma    <= abs_a;
            mb    <= abs_b;
            neg_q <= is_signed && (a[WordWidth-1] ^ b[WordWidth-1]);
            neg_r <= is_signed && a[WordWidth-1];
            acc   <= '0;
            quot  <= abs_a;
            rem   <= '0;
            cnt   <= '0;
            state <= is_div ? ST_DIV : ST_MUL;
          end
        end
        ST_MUL: begin
          acc <= acc + pprod_shift;
          cnt <= cnt + 1'b1;
          if (cnt == CntWidth'(3)) begin
            state <= ST_FIX;
          end
        end
        ST_DIV: begin
          if (!rem_diff[WordWidth]) begin
            rem  <= rem_diff;
            quot <= {quot[WordWidth-2:0], 1'b1};
          end else begin
            rem  <= rem_shift;
            quot <= {quot[WordWidth-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CntWidth'(WordWidth-1)) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Sign fix-up in the final cycle.
  always_comb begin
    if (is_div) begin
      lo_out = neg_q ? -quot : quot;
      hi_out = neg_r ? -rem[WordWidth-1:0] : rem[WordWidth-1:0];
    end else begin
      hi_out = neg_q ? acc_neg[2*WordWidth-1:WordWidth] : acc[2*WordWidth-1:WordWidth];
      lo_out = neg_q ? acc_neg[WordWidth-1:0] : acc[WordWidth-1:0];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    done |=> state == ST_IDLE)
    else $error("done held beyond one cycle");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !rem[WordWidth])
    else $error("partial remainder overflow");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> cnt < CntWidth'(4))
    else $error("multiply step count out of range");

endmodule

/* rtl/mieu_back.sv */
// ----------------------------------------------------------------------------
// MIPS integer execute unit back end
// Carries out queued items, holds HI and LO and drives the output register.
// ----------------------------------------------------------------------------
module mieu_back
  import mieu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_take,
  input  queue_item_t          q_item,
  output logic                 valid,
  input  logic                 stall,
  output logic [WordWidth-1:0] result_value,
  output logic                 write_reg,
  output logic [WordWidth-1:0] next_pc,
  output logic                 divide_by_zero
);

  logic                 busy;
  logic                 out_free;
  logic [WordWidth-1:0] hi_reg;
  logic [WordWidth-1:0] lo_reg;
  logic                 md_start;
  logic                 md_done;
  logic [WordWidth-1:0] md_hi;
  logic [WordWidth-1:0] md_lo;
  logic [WordWidth-1:0] rs;
  logic [WordWidth-1:0] rt;
  logic [WordWidth-1:0] pc4;
  logic [WordWidth-1:0] simm;
  logic [WordWidth-1:0] zimm;
  logic [WordWidth-1:0] btarget;
  logic [WordWidth-1:0] jtarget;
  logic [WordWidth-1:0] sum;
  logic [WordWidth-1:0] diff;
  logic [ShWidth-1:0]   samt;
  logic [WordWidth-1:0] sh_src;
  logic signed [WordWidth-1:0] sh_signed;
  logic                 zero_div;
  logic [WordWidth-1:0] res;
  logic                 wr;
  logic [WordWidth-1:0] npc;
  logic                 simple_fire;
  logic                 long_item;

  assign rs       = q_item.rs_value;
  assign rt       = q_item.rt_value;
  assign pc4      = q_item.pc_value + PcStep;
  assign zimm     = {16'b0, q_item.immediate_field[15:0]};
  assign simm     = q_item.immediate_field[15] ? (zimm | SextMask) : zimm;
  assign btarget  = pc4 + {simm[WordWidth-3:0], 2'b00};
  assign jtarget  = (pc4 & RegionMask) | {4'b0, q_item.immediate_field, 2'b00};
  assign zero_div = (q_item.cls == CLS_DIV) && (rt == '0);
  assign long_item = (q_item.cls != CLS_SIMPLE) && !zero_div;
  assign out_free = !valid || !stall;
  assign sh_src   = rt;
  assign sh_signed = rt;

  // Simple operations, computed combinationally.
  always_comb begin
    sum  = rs + ((q_item.op == OP_ADDI || q_item.op == OP_ADDIU) ? simm : rt);
    diff = rs - rt;
    samt = (q_item.op == OP_SLLV || q_item.op == OP_SRLV || q_item.op == OP_SRAV)
           ? rs[ShWidth-1:0] : q_item.shift_amount;
    res  = '0;
    wr   = 1'b0;
    npc  = pc4;
    case (q_item.op)
      OP_SLL, OP_SLLV: begin res = sh_src << samt; wr = 1'b1; end
      OP_SRL, OP_SRLV: begin res = sh_src >> samt; wr = 1'b1; end
      OP_SRA, OP_SRAV: begin res = WordWidth'(sh_signed >>> samt); wr = 1'b1; end
      OP_JR:   npc = rs;
      OP_JALR: begin res = pc4; wr = 1'b1; npc = rs; end
      OP_MOVZ: begin if (rt == '0) begin res = rs; wr = 1'b1; end end
      OP_MOVN: begin if (rt != '0) begin res = rs; wr = 1'b1; end end
      OP_MFHI: begin res = hi_reg; wr = 1'b1; end
      OP_MFLO: begin res = lo_reg; wr = 1'b1; end
      OP_ADD, OP_ADDU, OP_ADDI, OP_ADDIU: begin res = sum; wr = 1'b1; end
      OP_SUB, OP_SUBU: begin res = diff; wr = 1'b1; end
      OP_AND:  begin res = rs & rt; wr = 1'b1; end
      OP_OR:   begin res = rs | rt; wr = 1'b1; end
      OP_XOR:  begin res = rs ^ rt; wr = 1'b1; end
      OP_NOR:  begin res = ~(rs | rt); wr = 1'b1; end
      OP_SLT:  begin res = WordWidth'($signed(rs) < $signed(rt)); wr = 1'b1; end
      OP_SLTU: begin res = WordWidth'(rs < rt); wr = 1'b1; end
      OP_J:    npc = jtarget;
      OP_JAL:  begin res = pc4; wr = 1'b1; npc = jtarget; end
      OP_BEQ:  begin if (rs == rt) npc = btarget; end
      OP_BNE:  begin if (rs != rt) npc = btarget; end
      OP_BLEZ: begin if (rs == '0 || rs[WordWidth-1]) npc = btarget; end
      OP_BGTZ: begin if (rs != '0 && !rs[WordWidth-1]) npc = btarget; end
      OP_SLTI: begin res = WordWidth'($signed(rs) < $signed(simm)); wr = 1'b1; end
      OP_SLTIU: begin res = WordWidth'(rs < simm); wr = 1'b1; end
      OP_ANDI: begin res = rs & zimm; wr = 1'b1; end
      OP_ORI:  begin res = rs | zimm; wr = 1'b1; end
      OP_XORI: begin res = rs ^ zimm; wr = 1'b1; end
      OP_LUI:  begin res = {q_item.immediate_field[15:0], 16'b0}; wr = 1'b1; end
      default: begin end
    endcase
  end

  assign simple_fire = q_valid && !busy && !long_item && out_free;
  assign md_start    = q_valid && !busy && long_item && out_free;
  assign q_take      = simple_fire || (busy && md_done);

  mieu_muldiv u_muldiv (
    .clk       (clk),
    .rst       (rst),
    .start     (md_start),
    .is_div    (q_item.cls == CLS_DIV),
    .is_signed (q_item.is_signed),
    .a         (rs),
    .b         (rt),
    .done      (md_done),
    .hi_out    (md_hi),
    .lo_out    (md_lo)
  );

  // Control, HI/LO and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      valid  <= 1'b0;
      hi_reg <= '0;
      lo_reg <= '0;
    end else begin
      // A new result beat loads the register; otherwise an accepted beat leaves it.
      if (simple_fire || (busy && md_done)) begin
        valid <= 1'b1;
      end else if (!stall) begin
        valid <= 1'b0;
      end
      if (md_start) begin
        busy <= 1'b1;
      end
      if (busy && md_done) begin
        busy           <= 1'b0;
        hi_reg         <= md_hi;
        lo_reg         <= md_lo;
        result_value   <= '0;
        write_reg      <= 1'b0;
        next_pc        <= pc4;
        divide_by_zero <= 1'b0;
      end
      if (simple_fire) begin
        if (q_item.op == OP_MTHI) begin
          hi_reg <= rs;
        end
        if (q_item.op == OP_MTLO) begin
          lo_reg <= rs;
        end
        result_value   <= wr ? res : '0;
        write_reg      <= wr;
        next_pc        <= npc;
        divide_by_zero <= zero_div;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    busy |-> !simple_fire)
    else $error("simple item issued while multiply or divide is running");
  assert property (@(posedge clk) disable iff (rst)
    md_done |-> busy)
    else $error("multiply or divide finished without a start");
  assert property (@(posedge clk) disable iff (rst)
    q_take |=> valid)
    else $error("item taken without a result beat");

endmodule

/* rtl/mips_integer_execute_unit.sv */
// Simple operations pass through a queue slot and the output register;
// mult/multu and div/divu also pass through the four-step multiplier or the
// bit-serial divider. Throughput: one item per cycle for simple operations
// while the output is free; multiply and divide occupy the back end until done.
// A two-entry queue separates front and back. Reset (rst, synchronous) empties
// the queue, drops the output beat and clears HI and LO.
// ----------------------------------------------------------------------------
// MIPS integer execute unit
// Executes MIPS32 integer operations with HI/LO, branches and jumps.
// ----------------------------------------------------------------------------
module mips_integer_execute_unit
  import mieu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OpWidth-1:0]   op,
  input  logic [WordWidth-1:0] rs_value,
  input  logic [WordWidth-1:0] rt_value,
  input  logic [ShWidth-1:0]   shift_amount,
  input  logic [ImmWidth-1:0]  immediate_field,
  input  logic [WordWidth-1:0] pc_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WordWidth-1:0] result_value,
  output logic                 write_reg,
  output logic [WordWidth-1:0] next_pc,
  output logic                 divide_by_zero
);

  logic        q_valid;
  logic        q_take;
  queue_item_t q_item;

  mieu_front u_front (
    .clk             (clk),
    .rst             (rst),
    .valid           (in_valid),
    .stall           (in_stall),
    .op              (op),
    .rs_value        (rs_value),
    .rt_value        (rt_value),
    .shift_amount    (shift_amount),
    .immediate_field (immediate_field),
    .pc_value        (pc_value),
    .q_valid         (q_valid),
    .q_take          (q_take),
    .q_item          (q_item)
  );

  mieu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_take         (q_take),
    .q_item         (q_item),
    .valid          (out_valid),
    .stall          (out_stall),
    .result_value   (result_value),
    .write_reg      (write_reg),
    .next_pc        (next_pc),
    .divide_by_zero (divide_by_zero)
  );

endmodule

/* test/mips_integer_execute_unit_checker.sv */
// ----------------------------------------------------------------------------
// Execute unit result checker
// Watches the input and output channels, predicts each result from its own
// copy of HI and LO, and compares every output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module mips_integer_execute_unit_checker
  import mieu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [OpWidth-1:0]   op,
  input  logic [WordWidth-1:0] rs_value,
  input  logic [WordWidth-1:0] rt_value,
  input  logic [ShWidth-1:0]   shift_amount,
  input  logic [ImmWidth-1:0]  immediate_field,
  input  logic [WordWidth-1:0] pc_value,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [WordWidth-1:0] result_value,
  input  logic                 write_reg,
  input  logic [WordWidth-1:0] next_pc,
  input  logic                 divide_by_zero,
  output int                   error_count,
  output int                   pending_count,
  output int                   result_count
);

  typedef struct {
    logic [WordWidth-1:0] value;
    logic                 wr;
    logic [WordWidth-1:0] npc;
    logic                 dz;
  } exec_result_t;

  exec_result_t         expected_results[$];
  logic [WordWidth-1:0] model_hi;
  logic [WordWidth-1:0] model_lo;

  assign pending_count = expected_results.size();

  // Signed arithmetic shift right of a word.
  function automatic logic [WordWidth-1:0] shift_arith(logic [WordWidth-1:0] v,
                                                       logic [4:0] n);
    return $unsigned($signed(v) >>> n);
  endfunction

  // Predicts one result and updates the model HI/LO registers.
  function automatic exec_result_t execute_item(
    logic [OpWidth-1:0] o, logic [WordWidth-1:0] rs, logic [WordWidth-1:0] rt,
    logic [ShWidth-1:0] sh, logic [ImmWidth-1:0] idx, logic [WordWidth-1:0] pc);
    exec_result_t         r;
    logic [WordWidth-1:0] simm;
    logic [WordWidth-1:0] zimm;
    logic [WordWidth-1:0] pc4;
    logic [WordWidth-1:0] btarget;
    logic [WordWidth-1:0] jtarget;
    logic [63:0]          prod;
    logic [WordWidth-1:0] ma;
    logic [WordWidth-1:0] mb;
    logic [WordWidth-1:0] q;
    logic [WordWidth-1:0] rm;
    zimm    = {16'h0, idx[15:0]};
    simm    = {{16{idx[15]}}, idx[15:0]};
    pc4     = pc + PcStep;
    btarget = pc4 + (simm << 2);
    jtarget = (pc4 & RegionMask) | {4'h0, idx, 2'b00};
    r.value = '0;
    r.wr    = 1'b0;
    r.npc   = pc4;
    r.dz    = 1'b0;
    case (o)
      OP_SLL:   begin r.value = rt << sh; r.wr = 1'b1; end
      OP_SRL:   begin r.value = rt >> sh; r.wr = 1'b1; end
      OP_SRA:   begin r.value = shift_arith(rt, sh); r.wr = 1'b1; end
      OP_SLLV:  begin r.value = rt << rs[4:0]; r.wr = 1'b1; end
      OP_SRLV:  begin r.value = rt >> rs[4:0]; r.wr = 1'b1; end
      OP_SRAV:  begin r.value = shift_arith(rt, rs[4:0]); r.wr = 1'b1; end
      OP_JR:    r.npc = rs;
      OP_JALR:  begin r.value = pc4; r.wr = 1'b1; r.npc = rs; end
      OP_MOVZ:  if (rt == 0) begin r.value = rs; r.wr = 1'b1; end
      OP_MOVN:  if (rt != 0) begin r.value = rs; r.wr = 1'b1; end
      OP_MFHI:  begin r.value = model_hi; r.wr = 1'b1; end
      OP_MTHI:  model_hi = rs;
      OP_MFLO:  begin r.value = model_lo; r.wr = 1'b1; end
      OP_MTLO:  model_lo = rs;
      OP_MULT:  begin
        prod = $unsigned(64'($signed(rs)) * 64'($signed(rt)));
        {model_hi, model_lo} = prod;
      end
      OP_MULTU: begin
        prod = {32'h0, rs} * {32'h0, rt};
        {model_hi, model_lo} = prod;
      end
      OP_DIV: begin
        if (rt == 0) begin
          r.dz = 1'b1;
        end else begin
          ma = rs[31] ? -rs : rs;
          mb = rt[31] ? -rt : rt;
          q  = ma / mb;
          rm = ma % mb;
          model_lo = (rs[31] ^ rt[31]) ? -q : q;
          model_hi = rs[31] ? -rm : rm;
        end
      end
      OP_DIVU: begin
        if (rt == 0) begin
          r.dz = 1'b1;
        end else begin
          model_lo = rs / rt;
          model_hi = rs % rt;
        end
      end
      OP_ADD, OP_ADDU:   begin r.value = rs + rt; r.wr = 1'b1; end
      OP_SUB, OP_SUBU:   begin r.value = rs - rt; r.wr = 1'b1; end
      OP_AND:   begin r.value = rs & rt; r.wr = 1'b1; end
      OP_OR:    begin r.value = rs | rt; r.wr = 1'b1; end
      OP_XOR:   begin r.value = rs ^ rt; r.wr = 1'b1; end
      OP_NOR:   begin r.value = ~(rs | rt); r.wr = 1'b1; end
      OP_SLT:   begin r.value = {31'h0, $signed(rs) < $signed(rt)}; r.wr = 1'b1; end
      OP_SLTU:  begin r.value = {31'h0, rs < rt}; r.wr = 1'b1; end
      OP_J:     r.npc = jtarget;
      OP_JAL:   begin r.value = pc4; r.wr = 1'b1; r.npc = jtarget; end
      OP_BEQ:   if (rs == rt) r.npc = btarget;
      OP_BNE:   if (rs != rt) r.npc = btarget;
      OP_BLEZ:  if (rs == 0 || rs[31]) r.npc = btarget;
      OP_BGTZ:  if (rs != 0 && !rs[31]) r.npc = btarget;
      OP_ADDI, OP_ADDIU: begin r.value = rs + simm; r.wr = 1'b1; end
      OP_SLTI:  begin r.value = {31'h0, $signed(rs) < $signed(simm)}; r.wr = 1'b1; end
      OP_SLTIU: begin r.value = {31'h0, rs < simm}; r.wr = 1'b1; end
      OP_ANDI:  begin r.value = rs & zimm; r.wr = 1'b1; end
      OP_ORI:   begin r.value = rs | zimm; r.wr = 1'b1; end
      OP_XORI:  begin r.value = rs ^ zimm; r.wr = 1'b1; end
      OP_LUI:   begin r.value = {idx[15:0], 16'h0}; r.wr = 1'b1; end
      default:  ;
    endcase
    return r;
  endfunction

  // Predict on each accepted input beat and check each accepted output beat.
  always @(posedge clk) begin
    exec_result_t e;
    if (rst) begin
      model_hi <= '0;
      model_lo <= '0;
      expected_results.delete();
      error_count  <= 0;
      result_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          error_count <= error_count + 1;
          if (error_count < 10)
            $display("ERROR: unexpected output beat result=%h npc=%h",
                     result_value, next_pc);
        end else begin
          e = expected_results.pop_front();
          if (e.value !== result_value || e.wr !== write_reg ||
              e.npc !== next_pc || e.dz !== divide_by_zero) begin
            error_count <= error_count + 1;
            if (error_count < 10)
              $display("ERROR: expected val=%h wr=%b npc=%h dz=%b, got val=%h wr=%b npc=%h dz=%b",
                       e.value, e.wr, e.npc, e.dz,
                       result_value, write_reg, next_pc, divide_by_zero);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(execute_item(op, rs_value, rt_value, shift_amount,
                                                immediate_field, pc_value));
    end
  end

endmodule

/* test/mips_integer_execute_unit_test.sv */
// ----------------------------------------------------------------------------
// Execute unit testbench
// Drives directed and random instructions with bursty input and a stalling
// output, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module mips_integer_execute_unit_test;
  import mieu_pkg::*;

  localparam int RandomItems = 600;
  localparam int CycleLimit  = 200000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OpWidth-1:0]   op = '0;
  logic [WordWidth-1:0] rs_value = '0;
  logic [WordWidth-1:0] rt_value = '0;
  logic [ShWidth-1:0]   shift_amount = '0;
  logic [ImmWidth-1:0]  immediate_field = '0;
  logic [WordWidth-1:0] pc_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WordWidth-1:0] result_value;
  logic                 write_reg;
  logic [WordWidth-1:0] next_pc;
  logic                 divide_by_zero;
  int                   error_count;
  int                   pending_count;
  int                   result_count;
  int                   cycle_count = 0;
  int                   beats_sent = 0;

  always #5 clk = ~clk;

  mips_integer_execute_unit DUT (.*);
  mips_integer_execute_unit_checker checker_inst (.*);

  // Cycle counter with a hard timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver stall pattern: long free runs alternate with stretches of random stalls.
  always @(posedge clk) begin
    if (cycle_count % 512 < 128) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // Picks an operand word biased toward corner values.
  function automatic logic [WordWidth-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return 32'h80000000;
      3: return 32'h7FFFFFFF;
      4: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Sends one beat and holds it until accepted.
  task automatic send_beat(logic [OpWidth-1:0] o, logic [WordWidth-1:0] rs,
                           logic [WordWidth-1:0] rt, logic [ShWidth-1:0] sh,
                           logic [ImmWidth-1:0] idx, logic [WordWidth-1:0] pc);
    in_valid        <= 1'b1;
    op              <= o;
    rs_value        <= rs;
    rt_value        <= rt;
    shift_amount    <= sh;
    immediate_field <= idx;
    pc_value        <= pc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    int burst;
    int sel;
    logic [OpWidth-1:0] o;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every operation code with corner operands.
    for (int i = 0; i <= int'(OP_LUI); i++)
      send_beat(i[5:0], 32'h80000000, 32'hFFFFFFFF, 5'd31, 26'h3FF8000, 32'hFFFFFFFC);
    send_beat(OP_DIV, 32'h80000000, 32'hFFFFFFFF, 5'd0, '0, 32'h0);
    send_beat(OP_MFLO, '0, '0, '0, '0, '0);
    send_beat(OP_MFHI, '0, '0, '0, '0, '0);
    send_beat(OP_DIVU, 32'd7, 32'd0, 5'd0, 26'h3FFFFFF, 32'h0);
    send_beat(OP_MFHI, '0, '0, '0, '0, '0);
    send_beat(6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'd31, 26'h3FFFFFF, 32'h7FFFFFFF);
    send_beat(6'd42, 32'h0, 32'h0, 5'd0, 26'h0, 32'h0);

    // Random: bursts of mixed instructions with random gaps.
    while (beats_sent < RandomItems + 45) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) o = OpWidth'($urandom_range(42, 63));
        else if (sel < 3) o = OpWidth'($urandom_range(int'(OP_MFHI), int'(OP_DIVU)));
        else o = OpWidth'($urandom_range(0, int'(OP_LUI)));
        send_beat(o, pick_word(), pick_word(), ShWidth'($urandom), ImmWidth'($urandom),
                  $urandom);
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d instructions covering all opcodes, HI/LO traffic and divide by zero;",
             beats_sent);
    $display("checked %0d result beats with %0d mismatches.", result_count, error_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
